// ----- hdl/chca_pkg.sv -----
// ----------------------------------------------------------------------------
// chca_pkg - shared types and constants for canonical code assignment
// Command and status bundles between controller and datapath, field widths
// and request codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chca_pkg;

    // Payload widths fixed by the interface
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 16;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Longest length the walk visits (all a 5-bit length can hold)
    localparam logic [LEN_W-1:0] LEN_LIMIT = 5'd31;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;       // store the length of an accepted load beat
        logic lookup_rd;     // read length and code of an accepted lookup
        logic walk_start;    // arm the assignment walk
        logic walk_step;     // issue one walk read
        logic walk_close;    // final over-subscription check, close the set
        logic resp_capture;  // load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic walk_end;      // current walk read is the last one
    } t_status;

endpackage

`default_nettype wire

// ----- hdl/chca_datapath.sv -----
// ----------------------------------------------------------------------------
// chca_datapath - length/code stores, assignment walk and result register
// Holds the symbol length memory with per-entry valid bits, the code memory,
// the walk counters and running code, the Kraft sum and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chca_datapath #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire chca_pkg::t_cmd              i_cmd,
    output chca_pkg::t_status                o_status,
    input  wire [chca_pkg::SYM_W-1:0]        i_symbol,
    input  wire [chca_pkg::LEN_W-1:0]        i_code_length,
    output logic [chca_pkg::CODE_W-1:0]      o_code_word,
    output logic [chca_pkg::LEN_W-1:0]       o_code_bits,
    output logic                             o_found,
    output logic                             o_overflow
);

    // Only byte symbols can reach the store
    localparam int DEPTH = (NUM_SYMBOLS < 256) ? NUM_SYMBOLS : 256;
    localparam int AW    = $clog2(DEPTH);
    // Kraft sum: up to 256 terms of at most 2^(MAX_CODE_LEN-1)
    localparam int KW    = MAX_CODE_LEN + 9;

    localparam int LW = chca_pkg::LEN_W;
    localparam int CW = chca_pkg::CODE_W;

    // Stores
    logic [LW-1:0]    r_len_mem  [DEPTH];
    logic [CW-1:0]    r_code_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;

    // Set flags
    logic r_closed;
    logic r_overflow;

    // Read side
    logic [LW-1:0] r_len_rd;
    logic          r_vld_rd;
    logic [CW-1:0] r_code_rd;
    logic          r_look_ok;

    // Walk state
    logic [AW-1:0] r_walk_addr;
    logic [LW-1:0] r_walk_len;
    logic          r_cmp_v;
    logic [AW-1:0] r_cmp_addr;
    logic [LW-1:0] r_cmp_len;
    logic [CW-1:0] r_code;
    logic [LW-1:0] r_prev_len;
    logic          r_first;
    logic [KW-1:0] r_kraft;

    // Output register
    logic [CW-1:0] r_o_code;
    logic [LW-1:0] r_o_bits;
    logic          r_o_found;
    logic          r_o_ovf;

    logic             in_range;
    logic [AW-1:0]    a_sym;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic             walk_end;
    logic             hit;
    logic             len_over;
    logic [CW-1:0]    n_code;
    logic [5:0]       kraft_sh;
    logic [KW-1:0]    kraft_lim;
    logic [DEPTH-1:0] n_valid;
    logic             look_found;

    // Address decode
    assign in_range = ({1'b0, i_symbol} < 9'(DEPTH));
    assign a_sym    = i_symbol[AW-1:0];
    assign rd_addr  = i_cmd.walk_step ? r_walk_addr : a_sym;
    assign rd_en    = i_cmd.walk_step | i_cmd.lookup_rd;
    assign walk_end = (r_walk_addr == AW'(DEPTH - 1)) && (r_walk_len == chca_pkg::LEN_LIMIT);
    assign o_status.walk_end = walk_end;

    // Walk compare and next code: previous + 1, shifted by the length step
    assign hit       = r_cmp_v && r_vld_rd && (r_len_rd == r_cmp_len);
    assign len_over  = ({1'b0, r_cmp_len} > 6'(MAX_CODE_LEN));
    assign n_code    = r_first ? '0 : ((r_code + CW'(1)) << (r_cmp_len - r_prev_len));
    assign kraft_sh  = 6'(MAX_CODE_LEN) - {1'b0, r_cmp_len};
    assign kraft_lim = KW'(1) << MAX_CODE_LEN;

    // Valid bits after a load: a closed set starts over
    always_comb begin
        n_valid = r_closed ? '0 : r_valid;
        if (in_range) begin
            n_valid[a_sym] = 1'b1;
        end
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && in_range) begin
            r_len_mem[a_sym] <= i_code_length;
        end
        if (rd_en) begin
            r_len_rd <= r_len_mem[rd_addr];
            r_vld_rd <= r_valid[rd_addr];
        end
        if (i_cmd.lookup_rd) begin
            r_code_rd <= r_code_mem[a_sym];
            r_look_ok <= in_range;
        end
        if (hit) begin
            r_code_mem[r_cmp_addr] <= n_code;
        end
    end

    // Valid bits and set flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_closed   <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            if (i_cmd.load_wr) begin
                r_valid <= n_valid;
                if (r_closed) begin
                    r_closed   <= 1'b0;
                    r_overflow <= 1'b0;
                end
            end
            if (hit && len_over) begin
                r_overflow <= 1'b1;
            end
            if (i_cmd.walk_close) begin
                r_closed <= 1'b1;
                if (r_kraft > kraft_lim) begin
                    r_overflow <= 1'b1;
                end
            end
        end
    end

    // Walk pipeline valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.walk_step;
        end
    end

    // Walk counters: symbol inner, length outer
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_walk_addr <= '0;
            r_walk_len  <= LW'(1);
            r_first     <= 1'b1;
            r_kraft     <= '0;
            r_code      <= '0;
            r_prev_len  <= '0;
        end else begin
            if (i_cmd.walk_step) begin
                r_cmp_addr <= r_walk_addr;
                r_cmp_len  <= r_walk_len;
                if (r_walk_addr == AW'(DEPTH - 1)) begin
                    r_walk_addr <= '0;
                    r_walk_len  <= r_walk_len + LW'(1);
                end else begin
                    r_walk_addr <= r_walk_addr + AW'(1);
                end
            end
            if (hit) begin
                r_code     <= n_code;
                r_prev_len <= r_cmp_len;
                r_first    <= 1'b0;
                if (!len_over) begin
                    r_kraft <= r_kraft + (KW'(1) << kraft_sh);
                end
            end
        end
    end

    // Lookup result
    assign look_found = r_closed && r_look_ok && r_vld_rd && (r_len_rd != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_capture) begin
            r_o_found <= look_found;
            r_o_code  <= look_found ? r_code_rd : '0;
            r_o_bits  <= look_found ? r_len_rd : '0;
            r_o_ovf   <= r_overflow;
        end
    end

    assign o_code_word = r_o_code;
    assign o_code_bits = r_o_bits;
    assign o_found     = r_o_found;
    assign o_overflow  = r_o_ovf;

endmodule

`default_nettype wire

// ----- hdl/chca_ctrl.sv -----
// ----------------------------------------------------------------------------
// chca_ctrl - sequencer for loads, lookups and the assignment walk
// Owns the handshakes, the walk sequence and the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chca_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire                 i_req_type,
    input  wire                 i_last_load,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output chca_pkg::t_cmd      o_cmd,
    input  wire chca_pkg::t_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_WALK,
        S_DRAIN,
        S_CLOSE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   in_beat;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_beat     = i_in_valid && o_in_ready;

    // Commands
    assign o_cmd.load_wr      = in_beat && (i_req_type == chca_pkg::REQ_LOAD);
    assign o_cmd.lookup_rd    = in_beat && (i_req_type == chca_pkg::REQ_LOOKUP);
    assign o_cmd.walk_start   = o_cmd.load_wr && i_last_load;
    assign o_cmd.walk_step    = (r_state == S_WALK);
    assign o_cmd.walk_close   = (r_state == S_CLOSE);
    assign o_cmd.resp_capture = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.resp_capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.lookup_rd) begin
                        r_state <= S_LOOK;
                    end else if (o_cmd.walk_start) begin
                        r_state <= S_WALK;
                    end
                end
                S_LOOK: begin
                    if (o_cmd.resp_capture) begin
                        r_state <= S_IDLE;
                    end
                end
                S_WALK: begin
                    if (i_status.walk_end) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_CLOSE;
                end
                S_CLOSE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Closing load always enters the walk
    a_walk_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.walk_start |=> (r_state == S_WALK))
        else $error("closing load did not start the walk");

    // Last walk read is followed by drain then close
    a_walk_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && i_status.walk_end |=> (r_state == S_DRAIN) ##1 (r_state == S_CLOSE))
        else $error("walk did not end through drain and close");

    // A lookup with a free output slot answers on the next edge
    a_look_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) && !r_out_valid |=> (r_state == S_IDLE) && r_out_valid)
        else $error("lookup result not delivered");

    // No input beat is taken during the walk
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.walk_step |-> !o_in_ready && !o_cmd.resp_capture)
        else $error("input or result taken during walk");
`endif

endmodule

`default_nettype wire

// ----- hdl/canonical_huffman_code_assign.sv -----
// ----------------------------------------------------------------------------
// canonical_huffman_code_assign - canonical prefix code assignment
// Collects symbol lengths, assigns canonical codes when a set closes and
// answers code lookups.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   in      | i_in_valid/o_in_ready, i_req_type, i_symbol,   | in
//           | i_code_length, i_last_load                     |
//   out     | o_out_valid/i_out_ready, o_code_word,          | out
//           | o_code_bits, o_found, o_overflow               |
//
// A load beat writes the length memory; a lookup does one registered read of
// the length and code memories, then loads the output register.
// A closing load adds a walk over D = min(NUM_SYMBOLS, 256) entries:
// the length memory is read one entry per cycle for each length 1..31.
// Reset clears the per-entry valid bits at once; no clearing pass is needed.
// A lookup whose result finds the output register full holds until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module canonical_huffman_code_assign #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_req_type,
    input  wire  [7:0]  i_symbol,
    input  wire  [4:0]  i_code_length,
    input  wire         i_last_load,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [15:0] o_code_word,
    output logic [4:0]  o_code_bits,
    output logic        o_found,
    output logic        o_overflow
);

    chca_pkg::t_cmd    cmd;
    chca_pkg::t_status status;

    chca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_last_load (i_last_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    chca_datapath #(
        .NUM_SYMBOLS  (NUM_SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_symbol      (i_symbol),
        .i_code_length (i_code_length),
        .o_code_word   (o_code_word),
        .o_code_bits   (o_code_bits),
        .o_found       (o_found),
        .o_overflow    (o_overflow)
    );

endmodule

`default_nettype wire
